### rtl/sn3_pkg.sv
// Shared types and constants of the 3D simplex noise pipeline.
`timescale 1ns / 1ps
package sn3_pkg;

	// Internal fraction width of the lattice offsets (Q.24).
	localparam int IFRAC = 24;

	// Bit patterns of the gradient hash, indexed by {x bit, y bit, z bit}.
	localparam logic [5:0] GRAD_PAT [8] = '{6'h15, 6'h38, 6'h32, 6'h2c,
		6'h0d, 6'h13, 6'h07, 6'h2a};

	// Reciprocal multipliers for exact floor division by constants.
	// ceil(2^22 / 3): exact for dividends below 2^21.
	localparam logic [20:0] RECIP3_K22 = 21'd1398102;
	// ceil(2^31 / 9): exact for dividends below 2^28.
	localparam logic [27:0] RECIP9_K31 = 28'd238609295;
	// ceil(2^29 / 3): exact for dividends below 2^29.
	localparam logic [27:0] RECIP3_K29 = 28'd178956971;

	// Load enables of the skew stages.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} skew_en_t;

	// Load enables of the corner stages.
	typedef struct packed {
		logic c1;
		logic c2;
		logic c3;
		logic c4;
		logic c5;
		logic c6;
		logic c7;
		logic c8;
	} corner_en_t;

endpackage

### rtl/simplex_noise_3d.sv
// Top level of the pipelined 3D simplex noise generator.
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_ready   point_x, point_y, point_z (Q16.16)
// output    out        out_valid / out_ready noise_value (Q3.20)
//
// A transaction passes through 14 register stages: five for skew, floor and
// simplex ranking, eight in each of four parallel corner units, and one for
// the final sum and saturation. One transaction can enter per cycle while
// in_ready is high. Reset clears only the valid bits and live_q. A stall at
// the output backs up stage by stage; empty stages still load, so input
// stays open until every stage holds a transaction.
module simplex_noise_3d #(
	parameter int COORD_FRAC_BITS = 16,
	parameter int HASH_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [23:0] noise_value
);

	localparam int NS = 14;

	// Valid bit and load enable of each stage.
	logic [NS:1]   vld_q;
	logic [NS:1]   en;
	logic          live_q;

	sn3_pkg::skew_en_t   skew_en;
	sn3_pkg::corner_en_t corner_en;

	logic [2:0][sn3_pkg::IFRAC-1:0] frac;
	logic [2:0][HASH_BITS-1:0]      lattice;
	logic [2:0]                     off1, off2;
	logic [3:0][25:0]               contrib;
	logic [2:0]                     corner_off [4];

	logic signed [28:0] total;
	logic signed [23:0] noise_s14;

	// A stage loads when it is empty or when its content moves on.
	always_comb begin
		en[NS] = !vld_q[NS] || out_ready;
		for (int k = NS - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			live_q <= 1'b0;
		end else begin
			live_q <= 1'b1;
			if (en[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready  = en[1];
	assign out_valid = vld_q[NS];

	assign skew_en   = '{s1: en[1], s2: en[2], s3: en[3], s4: en[4], s5: en[5]};
	assign corner_en = '{c1: en[6], c2: en[7], c3: en[8], c4: en[9],
		c5: en[10], c6: en[11], c7: en[12], c8: en[13]};

	sn3_skew #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS),
		.HASH_BITS(HASH_BITS)
	) u_skew (
		.clk(clk),
		.en(skew_en),
		.point_x(point_x),
		.point_y(point_y),
		.point_z(point_z),
		.frac(frac),
		.lattice(lattice),
		.off1(off1),
		.off2(off2)
	);

	// Corners in order: base cube corner, one step, two steps, opposite corner.
	assign corner_off[0] = 3'b000;
	assign corner_off[1] = off1;
	assign corner_off[2] = off2;
	assign corner_off[3] = 3'b111;

	for (genvar g = 0; g < 4; g++) begin : g_corner
		sn3_corner #(
			.HASH_BITS(HASH_BITS)
		) u_corner (
			.clk(clk),
			.en(corner_en),
			.frac(frac),
			.lattice(lattice),
			.off(corner_off[g]),
			.contrib(contrib[g])
		);
	end

	// Each contribution carries a bias of 2^24; remove all four at once.
	always_comb begin
		total = 29'(contrib[0]) + 29'(contrib[1]) + 29'(contrib[2]) + 29'(contrib[3])
			- 29'sh400_0000;
	end

	always_ff @(posedge clk) begin
		if (en[NS]) begin
			if (total > 29'sd8388607) begin
				noise_s14 <= 24'sh7f_ffff;
			end else if (total < -29'sd8388608) begin
				noise_s14 <= -24'sh80_0000;
			end else begin
				noise_s14 <= total[23:0];
			end
		end
	end

	assign noise_value = noise_s14;

	// The number of transactions in flight changes only by the handshakes.
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		live_q |=> $countones(vld_q[NS:1]) == $past($countones(vld_q[NS:1]))
			+ $past(in_valid && in_ready) - $past(out_valid && out_ready))
		else $error("pipeline occupancy does not match handshakes");

	// The simplex path steps along one axis, then a second.
	a_simplex: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[5] |-> $onehot(off1) && $countones(off2) == 2 && (off1 & ~off2) == 3'b000)
		else $error("invalid simplex corner offsets");

	// A blocked stage keeps its transaction.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[5] && !en[5] |=> vld_q[5] && $stable(off1) && $stable(frac))
		else $error("stalled stage lost its contents");

endmodule

### rtl/sn3_skew.sv
// Skew, floor and simplex selection stages of the noise pipeline.
`timescale 1ns / 1ps
module sn3_skew #(
	parameter int COORD_FRAC_BITS = 16,
	parameter int HASH_BITS = 8
) (
	input  logic                              clk,
	input  sn3_pkg::skew_en_t                 en,
	input  logic signed [31:0]                point_x,
	input  logic signed [31:0]                point_y,
	input  logic signed [31:0]                point_z,
	output logic [2:0][sn3_pkg::IFRAC-1:0]    frac,
	output logic [2:0][HASH_BITS-1:0]         lattice,
	output logic [2:0]                        off1,
	output logic [2:0]                        off2
);

	localparam int XW = COORD_FRAC_BITS + HASH_BITS;
	localparam int SW = 41;

	logic signed [2:0][31:0]          p_s1, p_s2, p_s3;
	logic [35:0]                      n_s1;
	logic [15:0]                      qa_s2;
	logic [19:0]                      rb_s2;
	logic [33:0]                      s_s3;
	logic [2:0][sn3_pkg::IFRAC-1:0]   fr_s4, fr_s5;
	logic [2:0][HASH_BITS-1:0]        lat_s4, lat_s5;
	logic [2:0]                       off1_s5, off2_s5;

	logic signed [35:0] sum36;
	logic [38:0]        pa;
	logic [17:0]        a_hi, qa3;
	logic [40:0]        pb;
	logic [33:0]        s_off;
	logic [2:0][SW-1:0] xs;
	logic [2:0]         o1, o2;

	// Offset the coordinate sum by 3*2^33 so the division by three is unsigned.
	always_comb begin
		sum36 = 36'(point_x) + 36'(point_y) + 36'(point_z);
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			p_s1 <= {point_x, point_y, point_z};
			n_s1 <= 36'(sum36) + 36'h6_0000_0000;
		end
	end

	// Upper 18 bits divided by three; the remainder joins the low bits.
	always_comb begin
		a_hi = n_s1[35:18];
		pa   = {21'd0, a_hi} * {18'd0, sn3_pkg::RECIP3_K22};
		qa3  = {1'b0, pa[37:22], 1'b0} + {2'b0, pa[37:22]};
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			p_s2  <= p_s1;
			qa_s2 <= pa[37:22];
			rb_s2 <= {2'(a_hi - qa3), n_s1[17:0]};
		end
	end

	always_comb begin
		pb    = {21'd0, rb_s2} * {20'd0, sn3_pkg::RECIP3_K22};
		s_off = {qa_s2, pb[39:22]};
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			p_s3 <= p_s2;
			s_s3 <= {~s_off[33], s_off[32:0]};
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			xs[k] = SW'(signed'(p_s3[2-k])) + SW'(signed'(s_s3));
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			for (int k = 0; k < 3; k++) begin
				lat_s4[k] <= xs[k][XW-1:COORD_FRAC_BITS];
				fr_s4[k]  <= sn3_pkg::IFRAC'(xs[k][COORD_FRAC_BITS-1:0])
					<< (sn3_pkg::IFRAC - COORD_FRAC_BITS);
			end
		end
	end

	// Rank the fractions; ties fall to the later branch. Bit k marks axis k.
	always_comb begin
		if (fr_s4[0] > fr_s4[1]) begin
			if (fr_s4[1] > fr_s4[2]) begin
				o1 = 3'b001; o2 = 3'b011;
			end else if (fr_s4[0] > fr_s4[2]) begin
				o1 = 3'b001; o2 = 3'b101;
			end else begin
				o1 = 3'b100; o2 = 3'b101;
			end
		end else begin
			if (fr_s4[0] > fr_s4[2]) begin
				o1 = 3'b010; o2 = 3'b011;
			end else if (fr_s4[1] > fr_s4[2]) begin
				o1 = 3'b010; o2 = 3'b110;
			end else begin
				o1 = 3'b100; o2 = 3'b110;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			fr_s5   <= fr_s4;
			lat_s5  <= lat_s4;
			off1_s5 <= o1;
			off2_s5 <= o2;
		end
	end

	assign frac    = fr_s5;
	assign lattice = lat_s5;
	assign off1    = off1_s5;
	assign off2    = off2_s5;

endmodule

### rtl/sn3_corner.sv
// Contribution of one simplex corner: offset, falloff, gradient and product.
`timescale 1ns / 1ps
module sn3_corner #(
	parameter int HASH_BITS = 8
) (
	input  logic                            clk,
	input  sn3_pkg::corner_en_t             en,
	input  logic [2:0][sn3_pkg::IFRAC-1:0]  frac,
	input  logic [2:0][HASH_BITS-1:0]       lattice,
	input  logic [2:0]                      off,
	output logic [25:0]                     contrib
);

	logic signed [2:0][28:0] u_c1;
	logic [5:0]              pat_c1;
	logic [2:0][54:0]        sq_c2;
	logic signed [29:0]      dot_c2, dot_c3, dot_c4, dot_c5, dot_c6;
	logic                    pos_c3;
	logic [26:0]             y_c3;
	logic [23:0]             t24_c4;
	logic [22:0]             t2_c5;
	logic [20:0]             t4_c6;
	logic signed [51:0]      prod_c7;
	logic [25:0]             res_c8;

	logic signed [2:0][28:0] d29;
	logic signed [28:0]      dsum;
	logic [2:0][HASH_BITS-1:0] cc;
	logic [5:0]              pat;
	logic [2:0]              idx;
	logic signed [57:0]      sqf [3];
	logic signed [2:0][29:0] ue;
	logic signed [2:0][29:0] v;
	logic                    b5, b4, b3, b2;
	logic signed [29:0]      dot;
	logic [56:0]             sqsum;
	logic signed [57:0]      tt;
	logic [54:0]             py;
	logic [47:0]             p2;
	logic [45:0]             p4;
	logic signed [25:0]      q;
	logic [26:0]             qb;
	logic [54:0]             pq;

	// Offset from the corner in Q.24, then six times its unskewed value.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			d29[k] = 29'({5'b0, frac[k]}) - (off[k] ? 29'sh100_0000 : 29'sh0);
		end
		dsum = d29[0] + d29[1] + d29[2];
		for (int k = 0; k < 3; k++) begin
			cc[k] = lattice[k] + HASH_BITS'(off[k]);
		end
		pat = 6'd0;
		for (int i = 0; i < HASH_BITS; i++) begin
			idx = {cc[0][i], cc[1][i], cc[2][i]};
			pat = pat + sn3_pkg::GRAD_PAT[idx];
		end
	end

	always_ff @(posedge clk) begin
		if (en.c1) begin
			for (int k = 0; k < 3; k++) begin
				u_c1[k] <= (d29[k] <<< 2) + (d29[k] <<< 1) - dsum;
			end
			pat_c1 <= pat;
		end
	end

	// Squared offsets and the gradient dot product.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sqf[k] = signed'(u_c1[k]) * signed'(u_c1[k]);
			ue[k]  = 30'(signed'(u_c1[k]));
		end
		b5 = pat_c1[5];
		b4 = pat_c1[4];
		b3 = pat_c1[3];
		b2 = pat_c1[2];
		case (pat_c1[1:0])
			2'd1: begin
				v[0] = ue[1]; v[1] = ue[2]; v[2] = ue[0];
			end
			2'd2: begin
				v[0] = ue[2]; v[1] = ue[0]; v[2] = ue[1];
			end
			default: begin
				v[0] = ue[0]; v[1] = ue[1]; v[2] = ue[2];
			end
		endcase
		dot = (b5 == b3) ? v[0] : -v[0];
		if (pat_c1[1:0] == 2'd0) begin
			dot = dot + ((b5 == b4) ? v[1] : -v[1]);
			dot = dot + ((b5 != (b4 ^ b3)) ? v[2] : -v[2]);
		end else if (b2) begin
			dot = dot + ((b5 == b4) ? v[1] : -v[1]);
		end else begin
			dot = dot + ((b5 != (b4 ^ b3)) ? v[2] : -v[2]);
		end
	end

	always_ff @(posedge clk) begin
		if (en.c2) begin
			for (int k = 0; k < 3; k++) begin
				sq_c2[k] <= sqf[k][54:0];
			end
			dot_c2 <= dot;
		end
	end

	// Falloff numerator T; the low 26 bits only enter the test for a positive T.
	always_comb begin
		sqsum = 57'(sq_c2[0]) + 57'(sq_c2[1]) + 57'(sq_c2[2]);
		tt    = 58'sh12_0000_0000_0000 - signed'({1'b0, sqsum});
	end

	always_ff @(posedge clk) begin
		if (en.c3) begin
			pos_c3 <= !tt[57] && (tt != 58'sd0);
			y_c3   <= tt[52:26];
			dot_c3 <= dot_c2;
		end
	end

	// t in Q.24 is floor(T / 2^26) divided by nine.
	always_comb begin
		py = {28'd0, y_c3} * {27'd0, sn3_pkg::RECIP9_K31};
	end

	always_ff @(posedge clk) begin
		if (en.c4) begin
			t24_c4 <= pos_c3 ? py[54:31] : 24'd0;
			dot_c4 <= dot_c3;
		end
	end

	always_comb begin
		p2 = {24'd0, t24_c4} * {24'd0, t24_c4};
	end

	always_ff @(posedge clk) begin
		if (en.c5) begin
			t2_c5  <= p2[46:24];
			dot_c5 <= dot_c4;
		end
	end

	always_comb begin
		p4 = {23'd0, t2_c5} * {23'd0, t2_c5};
	end

	always_ff @(posedge clk) begin
		if (en.c6) begin
			t4_c6  <= p4[44:24];
			dot_c6 <= dot_c5;
		end
	end

	always_ff @(posedge clk) begin
		if (en.c7) begin
			prod_c7 <= 52'(signed'({1'b0, t4_c6})) * 52'(dot_c6);
		end
	end

	// Floor by 2^26 is an arithmetic shift; the floor by three runs on a value
	// biased by 3*2^24, so the result carries a bias of 2^24.
	always_comb begin
		q  = prod_c7[51:26];
		qb = 27'(q) + 27'h300_0000;
		pq = {28'd0, qb} * {27'd0, sn3_pkg::RECIP3_K29};
	end

	always_ff @(posedge clk) begin
		if (en.c8) begin
			res_c8 <= pq[54:29];
		end
	end

	assign contrib = res_c8;

endmodule

### sim/tb_top.sv
// Self-checking testbench of the 3D simplex noise generator with a bit-exact noise predictor.
`timescale 1ns / 1ps
module tb_top;

	localparam int FRAC_BITS = 16;
	localparam int HASH_W = 8;
	localparam int N_RANDOM = 1600;
	localparam int PIPE_LATENCY = 14;
	localparam logic signed [63:0] ONE24 = 64'sd1 <<< 24;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] point_x = '0;
	logic signed [31:0] point_y = '0;
	logic signed [31:0] point_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [23:0] noise_value;

	point_t pending_points[$];
	logic signed [23:0] expected_noise[$];
	int error_count = 0;
	bit stimulus_done = 1'b0;
	bit idle_free = 1'b0;

	simplex_noise_3d #(.COORD_FRAC_BITS(FRAC_BITS), .HASH_BITS(HASH_W)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.out_valid(out_valid), .out_ready(out_ready), .noise_value(noise_value)
	);

	always #1 clk = ~clk;

	// Floor division by a positive divisor, rounding toward minus infinity.
	function automatic logic signed [63:0] div_floor(input logic signed [63:0] n,
		input logic signed [63:0] d);
		if (n >= 0) begin
			return n / d;
		end
		return -((-n + d - 1) / d);
	endfunction

	// Contribution of one simplex corner in Q.20.
	function automatic logic signed [63:0] corner_noise(input logic signed [63:0] fr[3],
		input bit off[3], input logic [HASH_W-1:0] lattice[3]);
		logic signed [63:0] d[3];
		logic signed [63:0] u[3];
		logic signed [63:0] v[3];
		logic signed [63:0] tt, t24, t2, t4, grad_dot, sum_d;
		logic [63:0] sq;
		logic [HASH_W-1:0] cc[3];
		logic [31:0] pat;
		logic b5, b4, b3, b2;
		logic [1:0] rot;
		sq = '0;
		pat = '0;
		for (int k = 0; k < 3; k++) begin
			d[k] = fr[k] - (off[k] ? ONE24 : 64'sd0);
		end
		sum_d = d[0] + d[1] + d[2];
		for (int k = 0; k < 3; k++) begin
			u[k] = 6 * d[k] - sum_d;
			sq += u[k] * u[k];
		end
		tt = (64'sd18 <<< 48) - $signed(sq);
		if (tt <= 0) begin
			return 0;
		end
		t24 = (tt >>> 24) / 36;
		t2 = (t24 * t24) >>> 24;
		t4 = (t2 * t2) >>> 24;
		for (int k = 0; k < 3; k++) begin
			cc[k] = lattice[k] + HASH_W'(off[k]);
		end
		for (int i = 0; i < HASH_W; i++) begin
			pat += 32'(sn3_pkg::GRAD_PAT[{cc[0][i], cc[1][i], cc[2][i]}]);
		end
		b5 = pat[5];
		b4 = pat[4];
		b3 = pat[3];
		b2 = pat[2];
		rot = pat[1:0];
		if (rot == 2'd1) begin
			v[0] = u[1]; v[1] = u[2]; v[2] = u[0];
		end else if (rot == 2'd2) begin
			v[0] = u[2]; v[1] = u[0]; v[2] = u[1];
		end else begin
			v[0] = u[0]; v[1] = u[1]; v[2] = u[2];
		end
		grad_dot = (b5 == b3) ? v[0] : -v[0];
		if (rot == 2'd0 || b2) begin
			grad_dot += (b5 == b4) ? v[1] : -v[1];
		end
		if (rot == 2'd0 || !b2) begin
			grad_dot += (b5 != (b4 ^ b3)) ? v[2] : -v[2];
		end
		return div_floor(t4 * grad_dot, 64'sd3 <<< 26);
	endfunction

	// Full noise value of one point, saturated to Q3.20.
	function automatic logic signed [23:0] simplex_noise(input point_t p);
		logic signed [63:0] pc[3];
		logic signed [63:0] fr[3];
		logic signed [63:0] skew, total, sk;
		logic [HASH_W-1:0] lattice[3];
		bit off[3];
		int mx, md, mn;
		pc[0] = p.x;
		pc[1] = p.y;
		pc[2] = p.z;
		skew = div_floor(pc[0] + pc[1] + pc[2], 3);
		for (int k = 0; k < 3; k++) begin
			sk = pc[k] + skew;
			lattice[k] = HASH_W'(sk >>> FRAC_BITS);
			fr[k] = (sk & ((64'sd1 <<< FRAC_BITS) - 1)) <<< (24 - FRAC_BITS);
			off[k] = 1'b0;
		end
		// Ties fall through to the later branch of each comparison.
		if (fr[0] > fr[1]) begin
			if (fr[1] > fr[2]) begin
				mx = 0; md = 1; mn = 2;
			end else if (fr[0] > fr[2]) begin
				mx = 0; md = 2; mn = 1;
			end else begin
				mx = 2; md = 0; mn = 1;
			end
		end else begin
			if (fr[0] > fr[2]) begin
				mx = 1; md = 0; mn = 2;
			end else if (fr[1] > fr[2]) begin
				mx = 1; md = 2; mn = 0;
			end else begin
				mx = 2; md = 1; mn = 0;
			end
		end
		total = corner_noise(fr, off, lattice);
		off[mx] = 1'b1;
		total += corner_noise(fr, off, lattice);
		off[md] = 1'b1;
		total += corner_noise(fr, off, lattice);
		off[mn] = 1'b1;
		total += corner_noise(fr, off, lattice);
		if (total > 64'sd8388607) begin
			total = 64'sd8388607;
		end else if (total < -64'sd8388608) begin
			total = -64'sd8388608;
		end
		return total[23:0];
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		error_count++;
	endtask

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $signed($urandom());
			1: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
			2: return $signed({16'($urandom_range(0, 7) - 4), 16'($urandom())});
			default: return $signed({16'($urandom()), 16'($urandom_range(0, 3) * 16'h4000)});
		endcase
	endfunction

	initial begin
		point_t p;
		logic signed [31:0] ext[6];
		ext = '{32'sh80000000, 32'sh7fffffff, 32'sh0, 32'shffffffff, 32'sh00010000, 32'sh00008000};
		// Directed: the range extremes, lattice points, equal fractions and small offsets.
		foreach (ext[i]) begin
			pending_points.push_back('{ext[i], ext[i], ext[i]});
		end
		pending_points.push_back('{32'sh80000000, 32'sh7fffffff, 32'sh0});
		pending_points.push_back('{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000});
		pending_points.push_back('{32'sh00004000, 32'sh00004000, 32'sh0});
		pending_points.push_back('{32'sh00001000, 32'sh00002000, 32'sh00003000});
		pending_points.push_back('{32'sh00003000, 32'sh00002000, 32'sh00001000});
		pending_points.push_back('{32'sh00002000, 32'sh00003000, 32'sh00001000});
		pending_points.push_back('{32'sh00001000, 32'sh00003000, 32'sh00002000});
		pending_points.push_back('{32'sh00FF8000, 32'sh01004000, 32'shFF00C000});
		pending_points.push_back('{32'sh0000AAAA, 32'sh55555555, 32'shAAAAAAAA});
		for (int i = 0; i < N_RANDOM; i++) begin
			p = '{rand_coord(), rand_coord(), rand_coord()};
			pending_points.push_back(p);
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Driver: valid stays up with a steady payload until the transaction is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_ready) begin
				if (pending_points.size() > 0 && (idle_free || $urandom_range(0, 99) >= 22)) begin
					point_x <= pending_points[0].x;
					point_y <= pending_points[0].y;
					point_z <= pending_points[0].z;
					expected_noise.push_back(simplex_noise(pending_points.pop_front()));
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
					if (pending_points.size() == 0) begin
						stimulus_done <= 1'b1;
					end
				end
			end
			out_ready <= idle_free || ($urandom_range(0, 99) >= 22);
		end
	end

	// Monitor: compare each result against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_noise.size() == 0) begin
				report_mismatch($sformatf("unexpected noise_value %0d", noise_value));
			end else if (noise_value !== expected_noise[0]) begin
				report_mismatch($sformatf("noise_value %0d expected %0d",
					noise_value, expected_noise[0]));
				void'(expected_noise.pop_front());
			end else begin
				void'(expected_noise.pop_front());
			end
		end
	end

	// A stretch with no idling on either side in the middle of the run.
	initial begin
		#1200;
		idle_free = 1'b1;
		#600;
		idle_free = 1'b0;
	end

	initial begin
		wait (stimulus_done && expected_noise.size() == 0);
		repeat (PIPE_LATENCY * 2) @(posedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#200000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
